/* hdl/fcfsm_pkg.sv */
// shared types and constants for the fcfs schedule metrics block
`timescale 1ns / 1ps
`default_nettype none
package fcfsm_pkg;

	localparam int MAX_JOBS_DEF  = 16;
	localparam int TIME_BITS_DEF = 16;

	localparam int IN_TIME_W = 16;
	localparam int JOB_ID_W  = 5;
	localparam int COMPL_W   = 21;
	localparam int TURN_W    = 20;
	localparam int WAIT_W    = 20;
	localparam int SUM_W     = 24;
	localparam int COUNT_W   = 5;

	typedef struct packed {
		logic [IN_TIME_W-1:0] arrival;
		logic [IN_TIME_W-1:0] burst;
		logic                 last_job;
	} in_t;

	typedef struct packed {
		logic [JOB_ID_W-1:0]  job_id;
		logic [IN_TIME_W-1:0] arrival_out;
		logic [IN_TIME_W-1:0] burst_out;
		logic [COMPL_W-1:0]   completion;
		logic [TURN_W-1:0]    turnaround;
		logic [WAIT_W-1:0]    waiting;
		logic [SUM_W-1:0]     sum_turnaround;
		logic [SUM_W-1:0]     sum_waiting;
		logic [COUNT_W-1:0]   job_count;
		logic                 dropped;
		logic                 last_result;
	} out_t;

	// per-cycle commands to every sorter cell
	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctrl_t;

	// what the emit unit needs besides the head cell
	typedef struct packed {
		logic               issue;
		logic               last;
		logic [COUNT_W-1:0] job_count;
		logic               dropped;
	} emit_ctrl_t;

endpackage
`default_nettype wire

/* hdl/fcfs_schedule_metrics_core.sv */
// top level: sorted job chain, load/emit control and result register
`timescale 1ns / 1ps
`default_nettype none
// Jobs are taken one request per cycle while loading; each one is placed into
// a row of MAX_JOBS cells kept sorted by arrival (ties stay in load order).
// Jobs past MAX_JOBS are discarded and flagged. The request marked last_job
// ends the set: in_stall then stays high while the head cell is popped once
// per cycle, unless out_stall holds the result register, into the schedule
// arithmetic and the result register, so a set of N kept jobs emits N results.
// in_stall drops once the final result has been issued; the next set may load
// while that result still waits. job_count and the running totals let the
// consumer form the averages.
module fcfs_schedule_metrics_core #(
	parameter int MAX_JOBS  = fcfsm_pkg::MAX_JOBS_DEF,
	parameter int TIME_BITS = fcfsm_pkg::TIME_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  fcfsm_pkg::in_t       in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output fcfsm_pkg::out_t      out_data
);
	import fcfsm_pkg::*;

	localparam int ID_W  = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int CLK_W = TIME_BITS + $clog2(MAX_JOBS) + 2;
	localparam int EXT_W = TIME_BITS + IN_TIME_W;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] left_q;
	logic             drop_q;

	logic             in_acc;
	logic             full;
	logic             issue;
	logic [CNT_W-1:0] count_nxt;
	logic             drop_nxt;
	logic [EXT_W-1:0] arr_ext;
	logic [EXT_W-1:0] bur_ext;
	logic [TIME_BITS-1:0] new_arr;
	logic [TIME_BITS-1:0] new_bur;
	cell_ctrl_t       cctrl;
	emit_ctrl_t       ectrl;

	logic                 c_take  [MAX_JOBS];
	logic                 c_valid [MAX_JOBS];
	logic [TIME_BITS-1:0] c_arr   [MAX_JOBS];
	logic [TIME_BITS-1:0] c_bur   [MAX_JOBS];
	logic [ID_W-1:0]      c_id    [MAX_JOBS];

	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(MAX_JOBS));
	assign count_nxt = full ? count_q : count_q + CNT_W'(1);
	assign drop_nxt = drop_q || full;

	// keep only the low TIME_BITS of each time
	assign arr_ext = EXT_W'(in_data.arrival);
	assign bur_ext = EXT_W'(in_data.burst);
	assign new_arr = arr_ext[TIME_BITS-1:0];
	assign new_bur = bur_ext[TIME_BITS-1:0];

	assign issue = (state_q == ST_EMIT) && (!out_valid || !out_stall);

	assign cctrl.insert = in_acc && !full;
	assign cctrl.pop    = issue;

	assign ectrl.issue     = issue;
	assign ectrl.last      = (left_q == CNT_W'(1));
	assign ectrl.job_count = COUNT_W'(count_q);
	assign ectrl.dropped   = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			left_q  <= '0;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						count_q <= count_nxt;
						drop_q  <= drop_nxt;
						if (in_data.last_job) begin
							left_q  <= count_nxt;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (issue) begin
						left_q <= left_q - CNT_W'(1);
						if (left_q == CNT_W'(1)) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		logic                 p_take;
		logic                 p_valid;
		logic [TIME_BITS-1:0] p_arr;
		logic [TIME_BITS-1:0] p_bur;
		logic [ID_W-1:0]      p_id;
		logic                 n_valid;
		logic [TIME_BITS-1:0] n_arr;
		logic [TIME_BITS-1:0] n_bur;
		logic [ID_W-1:0]      n_id;

		if (i == 0) begin : g_first
			assign p_take  = 1'b0;
			assign p_valid = 1'b0;
			assign p_arr   = '0;
			assign p_bur   = '0;
			assign p_id    = '0;
		end else begin : g_mid
			assign p_take  = c_take[i-1];
			assign p_valid = c_valid[i-1];
			assign p_arr   = c_arr[i-1];
			assign p_bur   = c_bur[i-1];
			assign p_id    = c_id[i-1];
		end

		if (i == MAX_JOBS - 1) begin : g_last
			assign n_valid = 1'b0;
			assign n_arr   = '0;
			assign n_bur   = '0;
			assign n_id    = '0;
		end else begin : g_inner
			assign n_valid = c_valid[i+1];
			assign n_arr   = c_arr[i+1];
			assign n_bur   = c_bur[i+1];
			assign n_id    = c_id[i+1];
		end

		fcfsm_cell #(
			.TIME_BITS (TIME_BITS),
			.ID_W      (ID_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cctrl),
			.new_arr    (new_arr),
			.new_bur    (new_bur),
			.new_id     (count_q[ID_W-1:0]),
			.prev_take  (p_take),
			.prev_valid (p_valid),
			.prev_arr   (p_arr),
			.prev_bur   (p_bur),
			.prev_id    (p_id),
			.next_valid (n_valid),
			.next_arr   (n_arr),
			.next_bur   (n_bur),
			.next_id    (n_id),
			.take       (c_take[i]),
			.valid      (c_valid[i]),
			.arr        (c_arr[i]),
			.bur        (c_bur[i]),
			.id         (c_id[i])
		);
	end

	fcfsm_emit #(
		.TIME_BITS (TIME_BITS),
		.ID_W      (ID_W),
		.CLK_W     (CLK_W)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ectrl),
		.head_arr  (c_arr[0]),
		.head_bur  (c_bur[0]),
		.head_id   (c_id[0]),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

/* hdl/fcfsm_cell.sv */
// one cell of the sorted job chain: holds one job, inserts or shifts
`timescale 1ns / 1ps
`default_nettype none
module fcfsm_cell #(
	parameter int TIME_BITS = fcfsm_pkg::TIME_BITS_DEF,
	parameter int ID_W      = 4
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  fcfsm_pkg::cell_ctrl_t       ctrl,
	input  wire  [TIME_BITS-1:0]        new_arr,
	input  wire  [TIME_BITS-1:0]        new_bur,
	input  wire  [ID_W-1:0]             new_id,
	input  wire                         prev_take,
	input  wire                         prev_valid,
	input  wire  [TIME_BITS-1:0]        prev_arr,
	input  wire  [TIME_BITS-1:0]        prev_bur,
	input  wire  [ID_W-1:0]             prev_id,
	input  wire                         next_valid,
	input  wire  [TIME_BITS-1:0]        next_arr,
	input  wire  [TIME_BITS-1:0]        next_bur,
	input  wire  [ID_W-1:0]             next_id,
	output logic                        take,
	output logic                        valid,
	output logic [TIME_BITS-1:0]        arr,
	output logic [TIME_BITS-1:0]        bur,
	output logic [ID_W-1:0]             id
);
	import fcfsm_pkg::*;

	logic                 valid_q;
	logic [TIME_BITS-1:0] arr_q;
	logic [TIME_BITS-1:0] bur_q;
	logic [ID_W-1:0]      id_q;

	// strictly greater keeps ties in load order
	assign take  = !valid_q || (arr_q > new_arr);
	assign valid = valid_q;
	assign arr   = arr_q;
	assign bur   = bur_q;
	assign id    = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && take) begin
			valid_q <= prev_take ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			arr_q <= next_arr;
			bur_q <= next_bur;
			id_q  <= next_id;
		end else if (ctrl.insert && take) begin
			if (prev_take) begin
				arr_q <= prev_arr;
				bur_q <= prev_bur;
				id_q  <= prev_id;
			end else begin
				arr_q <= new_arr;
				bur_q <= new_bur;
				id_q  <= new_id;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/fcfsm_emit.sv */
// schedule arithmetic on the head job and the result register
`timescale 1ns / 1ps
`default_nettype none
module fcfsm_emit #(
	parameter int TIME_BITS = fcfsm_pkg::TIME_BITS_DEF,
	parameter int ID_W      = 4,
	parameter int CLK_W     = 21
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  fcfsm_pkg::emit_ctrl_t       ctrl,
	input  wire  [TIME_BITS-1:0]        head_arr,
	input  wire  [TIME_BITS-1:0]        head_bur,
	input  wire  [ID_W-1:0]             head_id,
	input  wire                         out_stall,
	output logic                        out_valid,
	output fcfsm_pkg::out_t             out_data
);
	import fcfsm_pkg::*;

	localparam int AW = (CLK_W > SUM_W) ? CLK_W : SUM_W;
	localparam int XW = (ID_W > JOB_ID_W) ? ID_W + 1 : JOB_ID_W + 1;

	logic [AW-1:0]    clock_q;
	logic [SUM_W-1:0] tot_turn_q;
	logic [SUM_W-1:0] tot_wait_q;
	logic             out_valid_q;
	out_t             out_q;

	logic [AW-1:0]    a_x;
	logic [AW-1:0]    b_x;
	logic [AW-1:0]    start;
	logic [AW-1:0]    done;
	logic [AW-1:0]    wait_t;
	logic [AW-1:0]    turn_t;
	logic [SUM_W-1:0] tt_next;
	logic [SUM_W-1:0] tw_next;
	logic [XW-1:0]    id_p1;

	assign a_x    = AW'(head_arr);
	assign b_x    = AW'(head_bur);
	// cpu idles until the job shows up
	assign start  = (clock_q < a_x) ? a_x : clock_q;
	assign done   = start + b_x;
	assign wait_t = start - a_x;
	assign turn_t = wait_t + b_x;
	assign tt_next = tot_turn_q + turn_t[SUM_W-1:0];
	assign tw_next = tot_wait_q + wait_t[SUM_W-1:0];
	assign id_p1  = XW'(head_id) + XW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			tot_turn_q  <= '0;
			tot_wait_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.issue) begin
				clock_q     <= ctrl.last ? '0 : done;
				tot_turn_q  <= ctrl.last ? '0 : tt_next;
				tot_wait_q  <= ctrl.last ? '0 : tw_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			out_q.job_id         <= id_p1[JOB_ID_W-1:0];
			out_q.arrival_out    <= a_x[IN_TIME_W-1:0];
			out_q.burst_out      <= b_x[IN_TIME_W-1:0];
			out_q.completion     <= done[COMPL_W-1:0];
			out_q.turnaround     <= turn_t[TURN_W-1:0];
			out_q.waiting        <= wait_t[WAIT_W-1:0];
			out_q.sum_turnaround <= tt_next;
			out_q.sum_waiting    <= tw_next;
			out_q.job_count      <= ctrl.job_count;
			out_q.dropped        <= ctrl.dropped;
			out_q.last_result    <= ctrl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

/* hdl/fcfsm_checker.sv */
// port-level checks for the fcfs schedule metrics block, bound to the top
`timescale 1ns / 1ps
`default_nettype none
module fcfsm_checker (
	input wire             clk,
	input wire             arst_n,
	input wire             in_valid,
	input wire             in_stall,
	input fcfsm_pkg::in_t  in_data,
	input wire             out_valid,
	input wire             out_stall,
	input fcfsm_pkg::out_t out_data
);
	import fcfsm_pkg::*;

	// a result held back by the consumer stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// the final request of a set closes the input side
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.last_job |=> in_stall)
		else $error("request taken after end of set");

	// input side only closes because a set ended
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall && in_data.last_job))
		else $error("stall without end of set");

	// while a non-final result is shown the set is still being emitted
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_result |-> in_stall)
		else $error("loading before set fully emitted");

endmodule

bind fcfs_schedule_metrics_core fcfsm_checker u_fcfsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

/* bench/testbench.sv */
// self-checking testbench for the fcfs schedule metrics core
`timescale 1ns / 1ps
module testbench;
	import fcfsm_pkg::*;

	localparam int MAX_JOBS = MAX_JOBS_DEF;
	localparam int SIDE_IN  = 0;
	localparam int SIDE_OUT = 1;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	fcfs_schedule_metrics_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// jobs waiting to be driven and schedule rows waiting to come out
	in_t  job_queue[$];
	out_t sched_expected[$];

	// predictor copy of the job store
	logic [IN_TIME_W-1:0] held_arr[MAX_JOBS];
	logic [IN_TIME_W-1:0] held_bur[MAX_JOBS];
	logic [3:0]           held_id[MAX_JOBS];
	int                   kept;
	logic                 overflow;

	int errors;
	int n_jobs;
	int n_sets;
	int n_rows;
	int n_overflow_sets;
	int calm_left[2];
	int in_gap;
	int out_hold;
	bit in_taken;

	task automatic report(string msg);
		$display("tb: mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0d expected %0d", what, got, want));
	endtask

	// gap for one request or hold for one result, with runs of back-to-back traffic
	function automatic int pick_gap(int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left[side] = $urandom_range(10, 40);
			return 0;
		end
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
	endfunction

	// store one job; on the closing job sort stably and build the schedule
	task automatic take_job(in_t job);
		logic [IN_TIME_W-1:0] a;
		logic [IN_TIME_W-1:0] b;
		logic [3:0]           id;
		int                   j;
		int unsigned          now;
		int unsigned          done;
		int unsigned          turn;
		int unsigned          wt;
		int unsigned          sum_t;
		int unsigned          sum_w;
		out_t                 row;
		if (kept < MAX_JOBS) begin
			held_arr[kept] = job.arrival;
			held_bur[kept] = job.burst;
			held_id[kept]  = 4'(kept);
			kept++;
		end else begin
			overflow = 1'b1;
		end
		if (!job.last_job)
			return;
		for (int i = 1; i < kept; i++) begin
			a  = held_arr[i];
			b  = held_bur[i];
			id = held_id[i];
			j  = i;
			while (j > 0 && held_arr[j-1] > a) begin
				held_arr[j] = held_arr[j-1];
				held_bur[j] = held_bur[j-1];
				held_id[j]  = held_id[j-1];
				j--;
			end
			held_arr[j] = a;
			held_bur[j] = b;
			held_id[j]  = id;
		end
		now   = 0;
		sum_t = 0;
		sum_w = 0;
		for (int k = 0; k < kept; k++) begin
			// cpu sits idle until the job shows up
			if (now < held_arr[k])
				now = held_arr[k];
			done  = now + held_bur[k];
			turn  = done - held_arr[k];
			wt    = turn - held_bur[k];
			now   = done;
			sum_t += turn;
			sum_w += wt;
			row.job_id         = {1'b0, held_id[k]} + 5'd1;
			row.arrival_out    = held_arr[k];
			row.burst_out      = held_bur[k];
			row.completion     = done[COMPL_W-1:0];
			row.turnaround     = turn[TURN_W-1:0];
			row.waiting        = wt[WAIT_W-1:0];
			row.sum_turnaround = sum_t[SUM_W-1:0];
			row.sum_waiting    = sum_w[SUM_W-1:0];
			row.job_count      = COUNT_W'(kept);
			row.dropped        = overflow;
			row.last_result    = (k == kept - 1);
			sched_expected.push_back(row);
		end
		n_sets++;
		if (overflow)
			n_overflow_sets++;
		kept     = 0;
		overflow = 1'b0;
	endtask

	task automatic add_job(logic [IN_TIME_W-1:0] a, logic [IN_TIME_W-1:0] b, logic last);
		in_t job;
		job.arrival  = a;
		job.burst    = b;
		job.last_job = last;
		job_queue.push_back(job);
		n_jobs++;
	endtask

	// monitor: sample handshakes, feed the predictor, check results
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && !in_stall;
			if (in_taken)
				take_job(in_data);
			if (out_valid === 1'b1 && !out_stall) begin
				n_rows++;
				if (sched_expected.size() == 0) begin
					report("result with nothing expected");
				end else begin
					out_t want;
					want = sched_expected.pop_front();
					check_field("job_id", out_data.job_id, want.job_id);
					check_field("arrival_out", out_data.arrival_out, want.arrival_out);
					check_field("burst_out", out_data.burst_out, want.burst_out);
					check_field("completion", out_data.completion, want.completion);
					check_field("turnaround", out_data.turnaround, want.turnaround);
					check_field("waiting", out_data.waiting, want.waiting);
					check_field("sum_turnaround", out_data.sum_turnaround,
						want.sum_turnaround);
					check_field("sum_waiting", out_data.sum_waiting, want.sum_waiting);
					check_field("job_count", out_data.job_count, want.job_count);
					check_field("dropped", out_data.dropped, want.dropped);
					check_field("last_result", out_data.last_result, want.last_result);
				end
				out_hold = pick_gap(SIDE_OUT);
			end
		end
	end

	// driver: one request at a time with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (job_queue.size() != 0) begin
					in_data  <= job_queue.pop_front();
					in_valid <= 1'b1;
					in_gap   = pick_gap(SIDE_IN);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: hold each result off for its drawn number of cycles
	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= (out_hold != 0);
			if (out_valid === 1'b1 && out_hold != 0)
				out_hold--;
		end
	end

	initial begin
		int len;
		int style;
		logic [IN_TIME_W-1:0] a;
		logic [IN_TIME_W-1:0] b;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		kept      = 0;
		overflow  = 1'b0;
		errors    = 0;
		n_jobs    = 0;
		n_sets    = 0;
		n_rows    = 0;
		n_overflow_sets = 0;
		calm_left[SIDE_IN]  = 0;
		calm_left[SIDE_OUT] = 0;
		in_gap    = 0;
		in_taken  = 1'b0;
		out_hold  = pick_gap(SIDE_OUT);

		// single-job sets at both extremes
		add_job(16'h0000, 16'h0000, 1'b1);
		add_job(16'hFFFF, 16'hFFFF, 1'b1);
		// ties keep load order, idle cpu before the first and the late job
		add_job(16'd40, 16'd7, 1'b0);
		add_job(16'd5, 16'd2, 1'b0);
		add_job(16'd5, 16'd0, 1'b0);
		add_job(16'd3, 16'd4, 1'b0);
		add_job(16'd5, 16'd1, 1'b1);
		// full set plus one: the closing job itself is dropped
		for (int i = 0; i < MAX_JOBS + 1; i++)
			add_job((i % 2 == 0) ? 16'hFFFF : 16'(i * 100), 16'hFFFF, i == MAX_JOBS);

		while (n_jobs < 405) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
				1, 2: len = $urandom_range(1, 3);
				default: len = $urandom_range(4, MAX_JOBS);
			endcase
			style = $urandom_range(0, 2);
			for (int i = 0; i < len; i++) begin
				case (style)
					0: a = 16'($urandom_range(0, 31));
					1: a = 16'($urandom());
					default: a = 16'(i * 200 + $urandom_range(0, 400));
				endcase
				case ($urandom_range(0, 5))
					0: b = 16'($urandom());
					1: b = 16'h0000;
					default: b = 16'($urandom_range(1, 150));
				endcase
				add_job(a, b, i == len - 1);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (job_queue.size() != 0 || in_valid || sched_expected.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("tb: %0d jobs in %0d sets, %0d with dropped jobs", n_jobs, n_sets,
			n_overflow_sets);
		$display("tb: %0d schedule rows checked", n_rows);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#10000000;
		$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
hdl/fcfsm_pkg.sv
hdl/fcfsm_cell.sv
hdl/fcfsm_emit.sv
hdl/fcfs_schedule_metrics_core.sv
hdl/fcfsm_checker.sv
bench/testbench.sv
